// ----- design/lte_pkg.sv -----
package lte_pkg;

	localparam int SAMPLE_WIDTH   = 32;
	localparam int CHAN_NUM_WIDTH = 5;
	localparam int STAMP_WIDTH    = 26;

endpackage

// ----- design/lte_queue.sv -----
module lte_queue #(
	parameter int WIDTH = 90
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	import lte_pkg::*;

	// two entries: head_q is always the oldest, next_q the one behind it
	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_TWO  = 2'd2;

	logic [WIDTH-1:0] head_q;
	logic [WIDTH-1:0] next_q;
	logic [1:0]       count_q;

	assign full    = (count_q == CNT_TWO);
	assign empty   = (count_q == CNT_NONE);
	assign rd_data = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_NONE;
		end else begin
			case ({wr, rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({wr, rd})
			2'b10: begin
				if (count_q == CNT_NONE) begin
					head_q <= wr_data;
				end else begin
					next_q <= wr_data;
				end
			end
			2'b01: begin
				head_q <= next_q;
			end
			2'b11: begin
				if (count_q == CNT_ONE) begin
					head_q <= wr_data;
				end else begin
					head_q <= next_q;
					next_q <= wr_data;
				end
			end
			default: begin
				head_q <= head_q;
			end
		endcase
	end

endmodule

// ----- design/lte_front.sv -----
module lte_front #(
	parameter int CHANNEL_COUNT = 32,
	parameter int TIME_WIDTH    = 26
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [lte_pkg::SAMPLE_WIDTH-1:0]  sample_bits,
	input  logic                              first_of_capture,
	output logic                              q_wr,
	output logic [2*CHANNEL_COUNT+TIME_WIDTH-1:0] q_data,
	input  logic                              q_full
);
	import lte_pkg::*;

	logic [CHANNEL_COUNT-1:0] prev_q;
	logic [TIME_WIDTH-1:0]    index_q;
	logic [CHANNEL_COUNT-1:0] cur;
	logic [CHANNEL_COUNT-1:0] changed;
	logic [TIME_WIDTH-1:0]    index_next;
	logic                     accept;

	assign full       = q_full;
	assign accept     = push && !q_full;
	assign cur        = sample_bits[CHANNEL_COUNT-1:0];
	assign changed    = prev_q ^ cur;
	assign index_next = index_q + {{(TIME_WIDTH-1){1'b0}}, 1'b1};

	// only samples with at least one transition need the back end
	assign q_wr   = accept && !first_of_capture && (|changed);
	assign q_data = {changed, cur, index_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			index_q <= '0;
		end else if (accept) begin
			prev_q <= cur;
			if (first_of_capture) begin
				index_q <= '0;
			end else begin
				index_q <= index_next;
			end
		end
	end

endmodule

// ----- design/lte_back.sv -----
module lte_back #(
	parameter int CHANNEL_COUNT = 32,
	parameter int TIME_WIDTH    = 26
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [2*CHANNEL_COUNT+TIME_WIDTH-1:0] q_data,
	input  logic                                  q_empty,
	output logic                                  q_rd,
	output logic                                  empty,
	input  logic                                  pop,
	output logic                                  new_level,
	output logic [lte_pkg::CHAN_NUM_WIDTH-1:0]    channel_number,
	output logic [lte_pkg::STAMP_WIDTH-1:0]       time_stamp,
	output logic                                  last_of_run
);
	import lte_pkg::*;

	logic [CHANNEL_COUNT-1:0]  mask_q;
	logic [CHANNEL_COUNT-1:0]  lvl_q;
	logic [TIME_WIDTH-1:0]     time_q;
	logic                      busy_q;
	logic                      out_valid_q;
	logic                      level_q;
	logic [CHAN_NUM_WIDTH-1:0] chan_q;
	logic [TIME_WIDTH-1:0]     stamp_q;
	logic                      last_q;

	logic [CHANNEL_COUNT-1:0]  lowest;
	logic [CHANNEL_COUNT-1:0]  rest;
	logic [CHAN_NUM_WIDTH-1:0] idx;
	logic                      pick_level;
	logic                      pick_last;
	logic                      step;
	logic                      out_taken;

	// isolate the lowest pending channel
	assign lowest     = mask_q & (~mask_q + {{(CHANNEL_COUNT-1){1'b0}}, 1'b1});
	assign rest       = mask_q & ~lowest;
	assign pick_level = |(lowest & lvl_q);
	assign pick_last  = ~(|rest);

	always_comb begin
		idx = '0;
		for (int i = 0; i < CHANNEL_COUNT; i++) begin
			if (lowest[i]) begin
				idx = idx | CHAN_NUM_WIDTH'(i);
			end
		end
	end

	assign out_taken = pop && out_valid_q;
	assign step      = busy_q && (!out_valid_q || pop);
	assign q_rd      = !q_empty && (!busy_q || (step && pick_last));

	assign empty          = !out_valid_q;
	assign new_level      = level_q;
	assign channel_number = chan_q;
	assign time_stamp     = STAMP_WIDTH'(stamp_q);
	assign last_of_run    = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_rd) begin
				busy_q <= 1'b1;
			end else if (step && pick_last) begin
				busy_q <= 1'b0;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (out_taken) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			mask_q <= q_data[2*CHANNEL_COUNT+TIME_WIDTH-1 -: CHANNEL_COUNT];
			lvl_q  <= q_data[CHANNEL_COUNT+TIME_WIDTH-1 -: CHANNEL_COUNT];
			time_q <= q_data[TIME_WIDTH-1:0];
		end else if (step) begin
			mask_q <= rest;
		end
		if (step) begin
			level_q <= pick_level;
			chan_q  <= idx;
			stamp_q <= time_q;
			last_q  <= pick_last;
		end
	end

endmodule

// ----- design/logic_transition_encoder_top.sv -----
// Channel   Handshake      Fields
// input     push / full    sample_bits, first_of_capture
// output    empty / pop    new_level, channel_number, time_stamp, last_of_run
//
// A sample is taken every cycle while the two-entry queue between front and
// back has room; a sample with no transition (or a capture start) never
// enters the queue. In the back end a sample with k changed channels gives
// k packets, one packet per cycle while pop is held, through the single
// output register. Reset clears the stored sample and index; stalls on pop
// back up into the queue and then raise full.
module logic_transition_encoder_top #(
	parameter int CHANNEL_COUNT = 32,
	parameter int TIME_WIDTH    = 26
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [lte_pkg::SAMPLE_WIDTH-1:0]  sample_bits,
	input  logic                              first_of_capture,
	output logic                              empty,
	input  logic                              pop,
	output logic                              new_level,
	output logic [lte_pkg::CHAN_NUM_WIDTH-1:0] channel_number,
	output logic [lte_pkg::STAMP_WIDTH-1:0]   time_stamp,
	output logic                              last_of_run
);
	import lte_pkg::*;

	localparam int QW = 2*CHANNEL_COUNT + TIME_WIDTH;

	logic          q_wr;
	logic          q_rd;
	logic          q_full;
	logic          q_empty;
	logic [QW-1:0] q_wdata;
	logic [QW-1:0] q_rdata;

	lte_front #(
		.CHANNEL_COUNT(CHANNEL_COUNT),
		.TIME_WIDTH   (TIME_WIDTH)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.sample_bits     (sample_bits),
		.first_of_capture(first_of_capture),
		.q_wr            (q_wr),
		.q_data          (q_wdata),
		.q_full          (q_full)
	);

	lte_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_data(q_wdata),
		.full   (q_full),
		.rd     (q_rd),
		.rd_data(q_rdata),
		.empty  (q_empty)
	);

	lte_back #(
		.CHANNEL_COUNT(CHANNEL_COUNT),
		.TIME_WIDTH   (TIME_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_data        (q_rdata),
		.q_empty       (q_empty),
		.q_rd          (q_rd),
		.empty         (empty),
		.pop           (pop),
		.new_level     (new_level),
		.channel_number(channel_number),
		.time_stamp    (time_stamp),
		.last_of_run   (last_of_run)
	);

endmodule

// ----- design/lte_checker.sv -----
module lte_checker #(
	parameter int CHANNEL_COUNT = 32
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               empty,
	input logic                               pop,
	input logic                               new_level,
	input logic [lte_pkg::CHAN_NUM_WIDTH-1:0] channel_number,
	input logic [lte_pkg::STAMP_WIDTH-1:0]    time_stamp,
	input logic                               last_of_run
);
	import lte_pkg::*;

	// a waiting packet holds until transferred
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(new_level) && $stable(channel_number)
			&& $stable(time_stamp) && $stable(last_of_run)))
		else $error("packet changed while waiting");

	// the rest of a run follows at once, same stamp, higher channel
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last_of_run) |=> (!empty
			&& (channel_number > $past(channel_number))
			&& (time_stamp == $past(time_stamp))))
		else $error("run broken");

	a_chan: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (32'(channel_number) < 32'(CHANNEL_COUNT)))
		else $error("channel out of range");

endmodule

bind logic_transition_encoder_top lte_checker #(
	.CHANNEL_COUNT(CHANNEL_COUNT)
) u_lte_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.empty         (empty),
	.pop           (pop),
	.new_level     (new_level),
	.channel_number(channel_number),
	.time_stamp    (time_stamp),
	.last_of_run   (last_of_run)
);

// ----- tb/sv/lte_packet_checker.sv -----
module lte_packet_checker #(
	parameter int CHANNEL_COUNT = 32,
	parameter int TIME_WIDTH    = 26
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  logic                               full,
	input  logic [lte_pkg::SAMPLE_WIDTH-1:0]   sample_bits,
	input  logic                               first_of_capture,
	input  logic                               empty,
	input  logic                               pop,
	input  logic                               new_level,
	input  logic [lte_pkg::CHAN_NUM_WIDTH-1:0] channel_number,
	input  logic [lte_pkg::STAMP_WIDTH-1:0]    time_stamp,
	input  logic                               last_of_run,
	output int                                 mismatch_count,
	output int                                 packets_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                               level;
		logic [lte_pkg::CHAN_NUM_WIDTH-1:0] channel;
		logic [lte_pkg::STAMP_WIDTH-1:0]    stamp;
		logic                               last;
	} packet_t;

	localparam logic [lte_pkg::SAMPLE_WIDTH-1:0] CHANNEL_MASK =
		lte_pkg::SAMPLE_WIDTH'((33'd1 << CHANNEL_COUNT) - 33'd1);

	logic [lte_pkg::SAMPLE_WIDTH-1:0] held_sample;
	logic [TIME_WIDTH-1:0]            sample_index;
	packet_t                          packets_due[$];

	always @(posedge clk or negedge arst_n) begin
		packet_t                          want;
		packet_t                          pkt;
		logic [lte_pkg::SAMPLE_WIDTH-1:0] cur;
		logic [lte_pkg::SAMPLE_WIDTH-1:0] changed;
		if (!arst_n) begin
			held_sample  = '0;
			sample_index = '0;
			packets_due.delete();
		end else begin
			// check the outgoing transfer against the oldest predicted packet
			if (pop && !empty) begin
				if (packets_due.size() == 0) begin
					$error("packet with none pending: channel %0d, time %0d",
						channel_number, time_stamp);
					mismatch_count++;
				end else begin
					want = packets_due.pop_front();
					if (new_level !== want.level) begin
						$error("new_level: expected %0d, actual %0d", want.level, new_level);
						mismatch_count++;
					end
					if (channel_number !== want.channel) begin
						$error("channel_number: expected %0d, actual %0d",
							want.channel, channel_number);
						mismatch_count++;
					end
					if (time_stamp !== want.stamp) begin
						$error("time_stamp: expected %0d, actual %0d", want.stamp, time_stamp);
						mismatch_count++;
					end
					if (last_of_run !== want.last) begin
						$error("last_of_run: expected %0d, actual %0d", want.last, last_of_run);
						mismatch_count++;
					end
				end
			end

			// predict the packets of an incoming sample
			if (push && !full) begin
				cur = sample_bits & CHANNEL_MASK;
				if (first_of_capture) begin
					held_sample  = cur;
					sample_index = '0;
				end else begin
					sample_index = sample_index + 1'b1;
					changed      = (held_sample ^ cur) & CHANNEL_MASK;
					for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
						if (changed[ch]) begin
							pkt.level   = cur[ch];
							pkt.channel = lte_pkg::CHAN_NUM_WIDTH'(ch);
							pkt.stamp   = lte_pkg::STAMP_WIDTH'(sample_index);
							// last when no higher channel changed
							pkt.last    = ((changed >> (ch + 1)) == '0);
							packets_due.push_back(pkt);
						end
					end
					held_sample = cur;
				end
			end
		end
		packets_pending = packets_due.size();
	end

endmodule

// ----- tb/sv/logic_transition_encoder_top_tb.sv -----
module logic_transition_encoder_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHANNEL_COUNT = 32;
	localparam int TIME_WIDTH    = 26;
	localparam int HOLD_CYCLES   = 200;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_ITEMS  = 195;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               push = 1'b0;
	logic                               full;
	logic [lte_pkg::SAMPLE_WIDTH-1:0]   sample_bits = '0;
	logic                               first_of_capture = 1'b0;
	logic                               empty;
	logic                               pop = 1'b0;
	logic                               new_level;
	logic [lte_pkg::CHAN_NUM_WIDTH-1:0] channel_number;
	logic [lte_pkg::STAMP_WIDTH-1:0]    time_stamp;
	logic                               last_of_run;

	int mismatch_count;
	int packets_pending;
	int cycle_count = 0;
	bit gaps_enabled = 1'b1;
	bit hold_pop_request = 1'b0;

	logic [lte_pkg::SAMPLE_WIDTH-1:0] last_bits = '0;

	logic_transition_encoder_top #(
		.CHANNEL_COUNT(CHANNEL_COUNT),
		.TIME_WIDTH(TIME_WIDTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample_bits(sample_bits),
		.first_of_capture(first_of_capture),
		.empty(empty),
		.pop(pop),
		.new_level(new_level),
		.channel_number(channel_number),
		.time_stamp(time_stamp),
		.last_of_run(last_of_run)
	);

	lte_packet_checker #(
		.CHANNEL_COUNT(CHANNEL_COUNT),
		.TIME_WIDTH(TIME_WIDTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample_bits(sample_bits),
		.first_of_capture(first_of_capture),
		.empty(empty),
		.pop(pop),
		.new_level(new_level),
		.channel_number(channel_number),
		.time_stamp(time_stamp),
		.last_of_run(last_of_run),
		.mismatch_count(mismatch_count),
		.packets_pending(packets_pending)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Called at a falling edge; returns at a falling edge after the transfer.
	task automatic send_sample(input logic [lte_pkg::SAMPLE_WIDTH-1:0] bits,
			input logic first);
		push             <= 1'b1;
		sample_bits      <= bits;
		first_of_capture <= first;
		last_bits         = bits;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
		if (gaps_enabled && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	function automatic logic [lte_pkg::SAMPLE_WIDTH-1:0] next_sample(
			input logic [lte_pkg::SAMPLE_WIDTH-1:0] prev);
		logic [lte_pkg::SAMPLE_WIDTH-1:0] bits;
		bits = prev;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: bits = prev;
			4, 5, 6: begin
				repeat ($urandom_range(1, 3))
					bits[$urandom_range(0, lte_pkg::SAMPLE_WIDTH - 1)] ^= 1'b1;
			end
			7, 8: bits = $urandom();
			default: begin
				case ($urandom_range(0, 3))
					0: bits = '0;
					1: bits = '1;
					2: bits = 32'hAAAA_AAAA;
					default: bits = 32'h5555_5555;
				endcase
			end
		endcase
		return bits;
	endfunction

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_pop_request) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_pop_request = 1'b0;
				pop <= 1'b1;
			end else if (gaps_enabled && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				pop <= 1'b1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// before any capture start: compare against the reset sample
		send_sample(32'h0000_0001, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'h0000_0000, 1'b0);
		send_sample(32'h0000_0000, 1'b0);
		// capture starts emit nothing, even back to back
		send_sample(32'hA5A5_A5A5, 1'b1);
		send_sample(32'h5A5A_5A5A, 1'b1);
		send_sample(32'h5A5A_5A5A, 1'b0);
		send_sample(32'hA5A5_A5A5, 1'b0);
		send_sample(32'hA5A5_A5A4, 1'b0);
		send_sample(32'h25A5_A5A4, 1'b0);
		send_sample(32'h0000_0000, 1'b1);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h0000_0001, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'h0000_0000, 1'b1);
		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'h7FFF_FFFE, 1'b0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 60)
				hold_pop_request = 1'b1;
			if (n == 120) begin
				// drain everything before going on
				push <= 1'b0;
				wait (packets_pending == 0);
				@(negedge clk);
			end
			if (n == RANDOM_ITEMS - 50)
				gaps_enabled = 1'b0;
			if (n >= 60 && n < 80)
				send_sample($urandom(), 1'b0);
			else if ($urandom_range(0, 39) == 0)
				send_sample(next_sample(last_bits), 1'b1);
			else
				send_sample(next_sample(last_bits), 1'b0);
		end
		push <= 1'b0;

		wait (packets_pending == 0);
		repeat (40) @(negedge clk);
		if (mismatch_count == 0 && packets_pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
